// ===== rtl/bbhs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbhs_pkg
// Shared constants, result type and header decode helpers for the binary blob
// header skipper.
// ----------------------------------------------------------------------------
package bbhs_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 32;

   localparam logic [31:0] LEGACY_MAGIC = 32'h0356_4B56;
   localparam logic [31:0] SIG_VALUE    = 32'h4B56_3300;
   localparam logic [31:0] SIG_MASK     = 32'hFFFF_FF00;
   localparam logic [31:0] TRAILER_WORD = 32'hFFEE_DD00;
   localparam logic [7:0]  BYTE_MASK    = 8'hFF;
   localparam logic [7:0]  GUID_BYTES   = 8'd16;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_TRUNC  = 2'd2;

   // Size capture slots.
   localparam logic [2:0] SLOT_SIZE0  = 3'd0;
   localparam logic [2:0] SLOT_SIZE1  = 3'd1;
   localparam logic [2:0] SLOT_BLOCKS = 3'd2;
   localparam logic [2:0] SLOT_BLOB   = 3'd3;
   localparam logic [2:0] SLOT_NONE   = 3'd4;

   // One result item; status sits in the lowest bits.
   typedef struct packed {
      logic [31:0] end_offset;
      logic [2:0]  format_version;
      logic [1:0]  status;
   } result_type;

   // Header length after the magic, per version.
   function automatic logic [7:0] header_length(logic [2:0] ver);
      logic [7:0] len;
      case (ver)
         3'd1:    len = 8'd36;
         3'd4:    len = 8'd68;
         3'd5:    len = 8'd116;
         default: len = 8'd60;
      endcase
      return len;
   endfunction

   // Which size slot header byte h feeds, SLOT_NONE for none.
   function automatic logic [2:0] slot_for(logic [2:0] ver, logic [7:0] h, logic unc);
      logic [7:0] w;
      logic [2:0] slot;
      w    = {h[7:2], 2'b00};
      slot = SLOT_NONE;
      if (ver == 3'd1) begin
         if (w == 8'd32) slot = SLOT_SIZE0;
      end else if (ver <= 3'd4 && ((w == 8'd44 && unc) || (w == 8'd48 && !unc))) begin
         slot = SLOT_SIZE0;
      end else if (w == 8'd52) begin
         slot = SLOT_BLOCKS;
      end else if (w == 8'd56) begin
         slot = SLOT_BLOB;
      end else if (ver == 3'd5) begin
         if ((w == 8'd68 && unc) || (w == 8'd72 && !unc)) slot = SLOT_SIZE0;
         else if ((w == 8'd76 && unc) || (w == 8'd80 && !unc)) slot = SLOT_SIZE1;
      end
      return slot;
   endfunction

   // Signed size field taken as a count, negative values as zero.
   function automatic logic [33:0] non_negative(logic [31:0] v);
      return v[31] ? 34'd0 : {3'b000, v[30:0]};
   endfunction

endpackage

// ===== rtl/bbhs_parser.sv =====
// ----------------------------------------------------------------------------
// bbhs_parser
// Byte-wise parse state: magic, header field capture, payload skip and
// trailer check. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module bbhs_parser #(
   parameter int OFFSET_WIDTH = bbhs_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic                  last,
   output logic                  res_valid,
   output bbhs_pkg::result_type  res
);

   localparam int PW = (OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

   typedef enum logic [2:0] {
      PH_ZEROS,
      PH_MAGIC,
      PH_HEADER,
      PH_SKIP,
      PH_TRAILER,
      PH_LEGACY,
      PH_DONE
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]              hidx_ff, hidx_in;
   logic [23:0]             shift_ff, shift_in;
   logic [2:0]              ver_ff, ver_in;
   logic                    unc_ff, unc_in;
   logic                    blocks_ff, blocks_in;
   logic [33:0]             skip_ff, skip_in;
   logic [31:0]             sizes_ff [4];
   logic [31:0]             sizes_in [4];

   logic [OFFSET_WIDTH-1:0] pos_inc;
   logic [OFFSET_WIDTH:0]   pos_plus4;
   logic [OFFSET_WIDTH-1:0] pos_trailer;
   logic [31:0]             magic;
   logic [2:0]              slot;
   logic [1:0]              lane;
   logic [33:0]             skip_total;
   logic [31:0]             cb;
   logic [7:0]              expect_byte;
   logic [1:0]              tidx;
   logic                    emit;
   logic [1:0]              emit_status;
   logic [2:0]              emit_ver;
   logic [OFFSET_WIDTH-1:0] emit_pos;
   logic [PW-1:0]           emit_wide;

   assign pos_inc     = (pos_ff == OFFSET_MAX) ? pos_ff : pos_ff + 1'b1;
   assign pos_plus4   = {1'b0, pos_ff} + (OFFSET_WIDTH+1)'(4);
   assign pos_trailer = pos_plus4[OFFSET_WIDTH] ? OFFSET_MAX : pos_plus4[OFFSET_WIDTH-1:0];
   assign magic       = {data_byte, shift_ff};
   assign lane        = hidx_ff[1:0];
   assign slot        = bbhs_pkg::slot_for(ver_ff, hidx_ff, unc_ff);
   assign tidx        = hidx_ff[1:0];
   assign expect_byte = 8'(bbhs_pkg::TRAILER_WORD >> {tidx, 3'b000}) & bbhs_pkg::BYTE_MASK;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      hidx_in     = hidx_ff;
      shift_in    = shift_ff;
      ver_in      = ver_ff;
      unc_in      = unc_ff;
      blocks_in   = blocks_ff;
      skip_in     = skip_ff;
      sizes_in    = sizes_ff;
      emit        = 1'b0;
      emit_status = bbhs_pkg::ST_OK;
      emit_ver    = 3'd0;
      emit_pos    = '0;
      skip_total  = '0;
      cb          = '0;

      case (phase_ff)
         PH_ZEROS: begin
            pos_in = pos_inc;
            if (data_byte != 8'd0) begin
               shift_in = {16'd0, data_byte};
               hidx_in  = 8'd1;
               phase_in = PH_MAGIC;
            end
         end
         PH_MAGIC: begin
            pos_in  = pos_inc;
            hidx_in = hidx_ff + 8'd1;
            if (lane == 2'd3) begin
               hidx_in = 8'd0;
               if (magic == bbhs_pkg::LEGACY_MAGIC) begin
                  phase_in = PH_LEGACY;
               end else if ((magic & bbhs_pkg::SIG_MASK) != bbhs_pkg::SIG_VALUE
                            || magic[7:0] < 8'd1 || magic[7:0] > 8'd5) begin
                  emit        = 1'b1;
                  emit_status = bbhs_pkg::ST_REJECT;
                  phase_in    = PH_DONE;
               end else begin
                  ver_in   = magic[2:0];
                  phase_in = PH_HEADER;
               end
            end else begin
               shift_in[{lane[1], lane[0], 3'b000} +: 8] = data_byte;
            end
         end
         PH_HEADER: begin
            pos_in = pos_inc;
            // The compression method word decides which size fields are used.
            if (hidx_ff == bbhs_pkg::GUID_BYTES) begin
               unc_in = (data_byte == 8'd0);
            end else if (hidx_ff > bbhs_pkg::GUID_BYTES
                         && hidx_ff < bbhs_pkg::GUID_BYTES + 8'd4 && data_byte != 8'd0) begin
               unc_in = 1'b0;
            end
            if (slot != bbhs_pkg::SLOT_NONE) begin
               if (lane == 2'd0) sizes_in[slot[1:0]] = {24'd0, data_byte};
               else sizes_in[slot[1:0]][{lane, 3'b000} +: 8] = data_byte;
            end
            hidx_in = hidx_ff + 8'd1;
            if (hidx_in == bbhs_pkg::header_length(ver_ff)) begin
               cb         = sizes_in[bbhs_pkg::SLOT_BLOCKS[1:0]];
               blocks_in  = (ver_ff >= 3'd2) && !cb[31] && (cb != 32'd0);
               skip_total = bbhs_pkg::non_negative(sizes_in[bbhs_pkg::SLOT_SIZE0[1:0]])
                          + ((ver_ff == 3'd5)
                             ? bbhs_pkg::non_negative(sizes_in[bbhs_pkg::SLOT_SIZE1[1:0]])
                             : 34'd0)
                          + ((blocks_in && unc_in)
                             ? bbhs_pkg::non_negative(sizes_in[bbhs_pkg::SLOT_BLOB[1:0]])
                             : 34'd0)
                          + (blocks_in ? 34'd4 : 34'd0);
               skip_in    = skip_total;
               if (skip_total == 34'd0) begin
                  if (ver_ff == 3'd1 || blocks_in) begin
                     emit        = 1'b1;
                     emit_status = bbhs_pkg::ST_OK;
                     emit_ver    = ver_ff;
                     emit_pos    = pos_in;
                     phase_in    = PH_DONE;
                  end else begin
                     phase_in = PH_TRAILER;
                     hidx_in  = 8'd0;
                  end
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            pos_in  = pos_inc;
            skip_in = skip_ff - 34'd1;
            if (skip_in == 34'd0) begin
               if (ver_ff == 3'd1 || blocks_ff) begin
                  emit        = 1'b1;
                  emit_status = bbhs_pkg::ST_OK;
                  emit_ver    = ver_ff;
                  emit_pos    = pos_in;
                  phase_in    = PH_DONE;
               end else begin
                  phase_in = PH_TRAILER;
                  hidx_in  = 8'd0;
               end
            end
         end
         PH_TRAILER: begin
            if (data_byte != expect_byte) begin
               emit        = 1'b1;
               emit_status = bbhs_pkg::ST_OK;
               emit_ver    = ver_ff;
               emit_pos    = pos_ff;
               phase_in    = PH_DONE;
            end else if (tidx == 2'd3) begin
               emit        = 1'b1;
               emit_status = bbhs_pkg::ST_OK;
               emit_ver    = ver_ff;
               emit_pos    = pos_trailer;
               phase_in    = PH_DONE;
            end else begin
               hidx_in = {6'd0, tidx + 2'd1};
            end
         end
         PH_LEGACY: begin
            pos_in = pos_inc;
         end
         default: begin
         end
      endcase

      // The end of the buffer forces the one result if none went out yet.
      if (last && !emit && phase_ff != PH_DONE) begin
         emit = 1'b1;
         case (phase_in)
            PH_HEADER, PH_SKIP: begin
               emit_status = bbhs_pkg::ST_TRUNC;
               emit_ver    = ver_in;
               emit_pos    = pos_in;
            end
            PH_TRAILER, PH_LEGACY: begin
               emit_status = bbhs_pkg::ST_OK;
               emit_ver    = ver_in;
               emit_pos    = pos_in;
            end
            default: begin
               emit_status = bbhs_pkg::ST_REJECT;
               emit_ver    = 3'd0;
               emit_pos    = '0;
            end
         endcase
      end

      if (last) begin
         phase_in  = PH_ZEROS;
         pos_in    = '0;
         hidx_in   = 8'd0;
         shift_in  = 24'd0;
         ver_in    = 3'd0;
         unc_in    = 1'b0;
         blocks_in = 1'b0;
         skip_in   = 34'd0;
      end
   end

   // End offset is reported on 32 bits, saturating.
   assign emit_wide              = PW'(emit_pos);
   assign res_valid              = step && emit;
   assign res.status             = emit_status;
   assign res.format_version     = emit_ver;
   assign res.end_offset         = (emit_wide > PW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : emit_wide[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ZEROS;
         pos_ff    <= '0;
         hidx_ff   <= 8'd0;
         shift_ff  <= 24'd0;
         ver_ff    <= 3'd0;
         unc_ff    <= 1'b0;
         blocks_ff <= 1'b0;
         skip_ff   <= 34'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         hidx_ff   <= hidx_in;
         shift_ff  <= shift_in;
         ver_ff    <= ver_in;
         unc_ff    <= unc_in;
         blocks_ff <= blocks_in;
         skip_ff   <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sizes_ff <= sizes_in;
      end
   end

endmodule

// ===== rtl/bbhs_out_buf.sv =====
// ----------------------------------------------------------------------------
// bbhs_out_buf
// Result register with one skid entry, so the parser keeps taking bytes
// while a finished result waits on the receiver.
// ----------------------------------------------------------------------------
module bbhs_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bbhs_pkg::result_type  push_data,
   output logic                  ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bbhs_pkg::result_type  out_data
);

   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   bbhs_pkg::result_type out_data_ff;
   bbhs_pkg::result_type skid_data_ff;

   assign ready     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

endmodule

// ===== rtl/binary_blob_header_skipper_top.sv =====
// ----------------------------------------------------------------------------
// binary_blob_header_skipper_top
// Streams one buffer a byte at a time and reports where its header and
// payload end.
// ----------------------------------------------------------------------------
// Usage: bytes of a buffer enter on the req_ stream, one per transfer, with
// req_tlast set on the final byte. Leading zero bytes are skipped, then the
// magic and versioned header are read and the described payload is skipped.
// Exactly one result per buffer leaves on the rsp_ stream: a status, the
// header version and the end offset. It is sent at the byte where the
// outcome is decided, or at the last byte at the latest; bytes after an
// early result are consumed silently until the last one.
// Throughput is one byte per cycle while req_tready is high. The parse of
// each byte is a single pass through the state logic; a result then
// reaches rsp_tvalid from the output register, via the skid entry on a stall.
// Reset clears the parse state; the first byte after reset starts a buffer.
// When the receiver stalls, one result waits in the output register and a
// second in a skid entry; only with both full does req_tready drop.
// ----------------------------------------------------------------------------
module binary_blob_header_skipper_top #(
   parameter int OFFSET_WIDTH = bbhs_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last byte of the buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [4:2] format_version,
                                    // [36:5] end_offset, [39:37] zero
);

   logic                 step;
   logic                 res_valid;
   bbhs_pkg::result_type res;
   bbhs_pkg::result_type rsp_data;
   logic                 buf_ready;

   // A byte transfer happens when req_tvalid is high and the skid entry is free.
   assign req_tready = buf_ready;
   assign step       = req_tvalid && buf_ready;

   bbhs_parser #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_tdata),
      .last      (req_tlast),
      .res_valid (res_valid),
      .res       (res)
   );

   bbhs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .ready     (buf_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {3'b000, rsp_data};

endmodule

// ===== dv/bbhs_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbhs_monitor
// Watches both streams of the header skipper, runs its own byte-level parse
// of every accepted byte and compares each result transfer against it.
// ----------------------------------------------------------------------------
module bbhs_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last byte of the buffer
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,    // [1:0] status, [4:2] format_version,
                                     // [36:5] end_offset, [39:37] zero
   output int          mismatch_count,
   output int          results_waiting,
   output int          results_matched
);

   typedef enum logic [3:0] {
      SCAN_ZEROS, SCAN_MAGIC, SCAN_HEADER, SCAN_SKIP, SCAN_TRAILER, SCAN_LEGACY, SCAN_DONE
   } scan_phase_type;

   scan_phase_type scan_phase;
   logic [31:0] byte_count;
   logic [7:0]  hdr_pos;
   logic [31:0] magic_word;
   logic [2:0]  hdr_version;
   logic        raw_payload;
   logic [31:0] size_field [4];
   logic        has_blocks;
   logic [33:0] bytes_to_skip;
   logic        result_done;

   bbhs_pkg::result_type expected_results [$];

   // A signed size field counts as zero when negative.
   function automatic logic [33:0] as_count(logic [31:0] v);
      return v[31] ? 34'd0 : 34'(v);
   endfunction

   task automatic clear_scan();
      scan_phase    = SCAN_ZEROS;
      byte_count    = '0;
      hdr_pos       = '0;
      magic_word    = '0;
      hdr_version   = '0;
      raw_payload   = 1'b0;
      for (int k = 0; k < 4; k++) size_field[k] = '0;
      has_blocks    = 1'b0;
      bytes_to_skip = '0;
      result_done   = 1'b0;
   endtask

   task automatic count_byte();
      if (byte_count != '1) byte_count = byte_count + 32'd1;
   endtask

   task automatic post_result(input logic [1:0] st, input logic [2:0] ver,
                              input logic [31:0] off);
      bbhs_pkg::result_type r;
      r.status         = st;
      r.format_version = ver;
      r.end_offset     = off;
      expected_results.push_back(r);
      result_done = 1'b1;
      scan_phase  = SCAN_DONE;
   endtask

   // Payload skipped: version 1 and blob-carrying headers end here, the
   // others may still carry a trailer.
   task automatic finish_skip();
      if (hdr_version == 3'd1 || has_blocks) begin
         post_result(bbhs_pkg::ST_OK, hdr_version, byte_count);
      end else begin
         scan_phase = SCAN_TRAILER;
         hdr_pos    = '0;
      end
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic is_last);
      logic [7:0]  h;
      logic [7:0]  w;
      logic [7:0]  hlen;
      logic [2:0]  slot;
      logic [33:0] skip;
      logic [31:0] nblocks;
      logic [1:0]  i;
      logic [32:0] tail_end;
      case (scan_phase)
         SCAN_ZEROS: begin
            count_byte();
            if (b != 8'd0) begin
               magic_word = {24'd0, b};
               hdr_pos    = 8'd1;
               scan_phase = SCAN_MAGIC;
            end
         end
         SCAN_MAGIC: begin
            count_byte();
            magic_word = magic_word | ({24'd0, b} << (8 * hdr_pos[1:0]));
            hdr_pos    = hdr_pos + 8'd1;
            if (hdr_pos >= 8'd4) begin
               hdr_pos = '0;
               if (magic_word == bbhs_pkg::LEGACY_MAGIC) begin
                  scan_phase = SCAN_LEGACY;
               end else if ((magic_word & bbhs_pkg::SIG_MASK) != bbhs_pkg::SIG_VALUE ||
                            magic_word[7:0] == 8'd0 || magic_word[7:0] > 8'd5) begin
                  post_result(bbhs_pkg::ST_REJECT, 3'd0, 32'd0);
               end else begin
                  hdr_version = magic_word[2:0];
                  scan_phase  = SCAN_HEADER;
               end
            end
         end
         SCAN_HEADER: begin
            h = hdr_pos;
            count_byte();
            // The compression method word is zero for raw payloads.
            if (h == bbhs_pkg::GUID_BYTES) raw_payload = 1'b1;
            if (h >= bbhs_pkg::GUID_BYTES && h < bbhs_pkg::GUID_BYTES + 8'd4 &&
                b != 8'd0) raw_payload = 1'b0;
            w    = {h[7:2], 2'b00};
            slot = bbhs_pkg::SLOT_NONE;
            if (hdr_version == 3'd1) begin
               if (w == 8'd32) slot = bbhs_pkg::SLOT_SIZE0;
            end else if (hdr_version != 3'd5 && w == (raw_payload ? 8'd44 : 8'd48)) begin
               slot = bbhs_pkg::SLOT_SIZE0;
            end else if (w == 8'd52) begin
               slot = bbhs_pkg::SLOT_BLOCKS;
            end else if (w == 8'd56) begin
               slot = bbhs_pkg::SLOT_BLOB;
            end else if (hdr_version == 3'd5 && w == (raw_payload ? 8'd68 : 8'd72)) begin
               slot = bbhs_pkg::SLOT_SIZE0;
            end else if (hdr_version == 3'd5 && w == (raw_payload ? 8'd76 : 8'd80)) begin
               slot = bbhs_pkg::SLOT_SIZE1;
            end
            if (slot != bbhs_pkg::SLOT_NONE) begin
               if (h[1:0] == 2'd0) size_field[slot[1:0]] = '0;
               size_field[slot[1:0]] = size_field[slot[1:0]] | ({24'd0, b} << (8 * h[1:0]));
            end
            hdr_pos = h + 8'd1;
            case (hdr_version)
               3'd1:    hlen = 8'd36;
               3'd4:    hlen = 8'd68;
               3'd5:    hlen = 8'd116;
               default: hlen = 8'd60;
            endcase
            if (hdr_pos >= hlen) begin
               skip = as_count(size_field[bbhs_pkg::SLOT_SIZE0[1:0]]);
               if (hdr_version == 3'd5)
                  skip = skip + as_count(size_field[bbhs_pkg::SLOT_SIZE1[1:0]]);
               nblocks    = size_field[bbhs_pkg::SLOT_BLOCKS[1:0]];
               has_blocks = 1'b0;
               if (hdr_version >= 3'd2 && !nblocks[31] && nblocks != 32'd0) begin
                  has_blocks = 1'b1;
                  if (raw_payload)
                     skip = skip + as_count(size_field[bbhs_pkg::SLOT_BLOB[1:0]]);
                  skip = skip + 34'd4;
               end
               bytes_to_skip = skip;
               if (bytes_to_skip == '0) finish_skip();
               else scan_phase = SCAN_SKIP;
            end
         end
         SCAN_SKIP: begin
            count_byte();
            bytes_to_skip = bytes_to_skip - 34'd1;
            if (bytes_to_skip == '0) finish_skip();
         end
         SCAN_TRAILER: begin
            // Trailer bytes do not advance the offset until all four match.
            i = hdr_pos[1:0];
            if (b != bbhs_pkg::TRAILER_WORD[8 * i +: 8]) begin
               post_result(bbhs_pkg::ST_OK, hdr_version, byte_count);
            end else if (i == 2'd3) begin
               tail_end = {1'b0, byte_count} + 33'd4;
               post_result(bbhs_pkg::ST_OK, hdr_version,
                           tail_end[32] ? 32'hFFFF_FFFF : tail_end[31:0]);
            end else begin
               hdr_pos = {6'd0, i} + 8'd1;
            end
         end
         SCAN_LEGACY: count_byte();
         default: ;
      endcase

      if (is_last) begin
         if (!result_done) begin
            case (scan_phase)
               SCAN_HEADER, SCAN_SKIP: begin
                  post_result(bbhs_pkg::ST_TRUNC, hdr_version, byte_count);
               end
               SCAN_TRAILER, SCAN_LEGACY: begin
                  post_result(bbhs_pkg::ST_OK, hdr_version, byte_count);
               end
               default: begin
                  post_result(bbhs_pkg::ST_REJECT, 3'd0, 32'd0);
               end
            endcase
         end
         clear_scan();
      end
   endtask

   task automatic check_result(input logic [39:0] raw);
      bbhs_pkg::result_type got;
      bbhs_pkg::result_type want;
      got = bbhs_pkg::result_type'(raw[36:0]);
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: unexpected result status %0d version %0d offset %0d",
                     got.status, got.format_version, got.end_offset);
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status || got.format_version !== want.format_version ||
             got.end_offset !== want.end_offset || raw[39:37] !== 3'd0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"mismatch: expected status %0d version %0d offset %0d, ",
                         "got %0d %0d %0d pad %0h"},
                        want.status, want.format_version, want.end_offset,
                        got.status, got.format_version, got.end_offset, raw[39:37]);
         end else begin
            results_matched++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         expected_results.delete();
         mismatch_count  = 0;
         results_matched = 0;
      end else begin
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
      results_waiting = expected_results.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the binary blob header skipper. Buffers of every
// kind are streamed in a byte per transfer while a separate monitor predicts
// and checks each result transfer.
// ----------------------------------------------------------------------------
module tb_top;

   // Run sizing: total byte transfers aimed for, and the fewest random
   // buffers in the closing stretch, which runs without idling.
   localparam int ITEM_TARGET  = 1150;
   localparam int TAIL_BUFFERS = 3;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {
      TAIL_FULL, TAIL_NONE, TAIL_PARTIAL, TAIL_WRONG, TAIL_JUNK, TAIL_CUT
   } tail_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int results_waiting;
   int results_matched;

   // Shared between the sender and the receiver process.
   bit gaps_on      = 1'b1;
   bit hold_request = 1'b0;

   int bytes_sent   = 0;
   int buffers_sent = 0;
   int cycle_count  = 0;

   logic [7:0] blob_bytes [$];
   logic [7:0] hdr_img [0:115];

   binary_blob_header_skipper_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bbhs_monitor monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .results_waiting (results_waiting),
      .results_matched (results_matched)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   // Receiver. Normally it idles in short random bursts; on request it holds
   // off for a long stretch so the result buffer fills and the input stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Sizes are mostly small so the payload skip completes; some are negative
   // and some huge, which ends in a truncated buffer.
   function automatic logic [31:0] rand_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return {1'b1, 31'($urandom)};
      if (r == 1) return $urandom;
      return 32'($urandom_range(0, 24));
   endfunction

   function automatic longint size_count(logic [31:0] v);
      return v[31] ? 64'd0 : longint'(v);
   endfunction

   task automatic push_word(input logic [31:0] w);
      for (int k = 0; k < 4; k++) blob_bytes.push_back(w[8 * k +: 8]);
   endtask

   task automatic place_word(input int off, input logic [31:0] v);
      for (int k = 0; k < 4; k++) hdr_img[off + k] = v[8 * k +: 8];
   endtask

   // One byte transfer, optionally preceded by an idle burst. Inputs move on
   // the falling edge and the handshake is sampled on the rising edge.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_blob();
      for (int i = 0; i < blob_bytes.size(); i++)
         send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
      buffers_sent++;
   endtask

   // The sender drops its valid first so the last byte is not taken twice.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_waiting != 0) @(negedge clock);
   endtask

   // Builds a versioned buffer: leading zeros, magic, header with the size
   // fields placed where this version and compression method keep them,
   // the payload the sizes describe, and the chosen ending.
   task automatic make_blob(input int ver, input int nz, input bit raw,
                            input logic [31:0] s0, input logic [31:0] s1,
                            input logic [31:0] nb, input logic [31:0] nblob,
                            input tail_kind_type tail_in);
      int            hlen;
      int            keep;
      longint        skip;
      tail_kind_type tail;
      tail = tail_in;
      case (ver)
         1:       hlen = 36;
         4:       hlen = 68;
         5:       hlen = 116;
         default: hlen = 60;
      endcase
      blob_bytes.delete();
      repeat (nz) blob_bytes.push_back(8'h00);
      push_word(bbhs_pkg::SIG_VALUE | 32'(ver));
      for (int k = 0; k < hlen; k++) hdr_img[k] = 8'($urandom);
      // Bytes 16 to 19 hold the compression method; all zero means raw.
      if (raw) begin
         for (int k = 16; k < 20; k++) hdr_img[k] = 8'h00;
      end else begin
         hdr_img[16 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
      end
      if (ver == 1) begin
         place_word(32, s0);
      end else begin
         place_word(52, nb);
         place_word(56, nblob);
         if (ver == 5) begin
            place_word(raw ? 68 : 72, s0);
            place_word(raw ? 76 : 80, s1);
         end else begin
            place_word(raw ? 44 : 48, s0);
         end
      end
      for (int k = 0; k < hlen; k++) blob_bytes.push_back(hdr_img[k]);

      skip = size_count(s0);
      if (ver == 5) skip += size_count(s1);
      if (ver >= 2 && !nb[31] && nb != 32'd0) skip += (raw ? size_count(nblob) : 0) + 4;
      if (skip > 200) begin
         // Too long to stream: the buffer ends inside the payload.
         repeat ($urandom_range(0, 20)) blob_bytes.push_back(8'($urandom));
         tail = TAIL_NONE;
      end else begin
         repeat (skip) blob_bytes.push_back(8'($urandom));
      end

      case (tail)
         TAIL_FULL: begin
            push_word(bbhs_pkg::TRAILER_WORD);
         end
         TAIL_PARTIAL: begin
            keep = $urandom_range(1, 3);
            for (int k = 0; k < keep; k++)
               blob_bytes.push_back(bbhs_pkg::TRAILER_WORD[8 * k +: 8]);
         end
         TAIL_WRONG: begin
            keep = $urandom_range(0, 3);
            for (int k = 0; k < keep; k++)
               blob_bytes.push_back(bbhs_pkg::TRAILER_WORD[8 * k +: 8]);
            blob_bytes.push_back(bbhs_pkg::TRAILER_WORD[8 * keep +: 8] ^
                                 8'($urandom_range(1, 255)));
         end
         TAIL_JUNK: begin
            push_word(bbhs_pkg::TRAILER_WORD);
            repeat ($urandom_range(1, 6)) blob_bytes.push_back(8'($urandom));
         end
         TAIL_CUT: begin
            keep = $urandom_range(nz + 1, blob_bytes.size() - 1);
            while (blob_bytes.size() > keep) void'(blob_bytes.pop_back());
         end
         default: ;
      endcase
   endtask

   initial begin
      int            pick;
      int            keep;
      int            rand_buffers;
      tail_kind_type tail;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---------------------------------------------------------------------
      // Directed buffers: legacy marker, zeros only, short and bad magics,
      // every version, both compression methods, blocks present and absent,
      // negative sizes, every trailer outcome and truncation.
      // ---------------------------------------------------------------------
      blob_bytes = '{8'h56, 8'h4B, 8'h56, 8'h03, 8'hFF, 8'h00, 8'h12};
      send_blob();
      blob_bytes = '{8'h00, 8'h00, 8'h00, 8'h56, 8'h4B, 8'h56, 8'h03};
      send_blob();
      blob_bytes = '{8'h00, 8'h00, 8'h00};
      send_blob();
      blob_bytes = '{8'h00, 8'h7F, 8'hFF};
      send_blob();
      blob_bytes = '{8'h01};
      send_blob();
      // A bad signature is rejected at once; the bytes behind it are ignored.
      blob_bytes.delete();
      push_word(32'h4C56_3301);
      push_word(32'hFFFF_FFFF);
      send_blob();
      // Correct signature but a version outside 1 to 5.
      for (int v = 0; v < 4; v++) begin
         blob_bytes.delete();
         push_word(bbhs_pkg::SIG_VALUE |
                   (v == 0 ? 32'd0 : v == 1 ? 32'd6 : v == 2 ? 32'd7 : 32'hFF));
         blob_bytes.push_back(8'hAA);
         send_blob();
      end
      // Valid magic and nothing else: truncated in the header.
      blob_bytes.delete();
      push_word(bbhs_pkg::SIG_VALUE | 32'd1);
      send_blob();

      make_blob(1, 0, 1'b1, 32'd5, 32'd0, 32'd0, 32'd0, TAIL_NONE);
      send_blob();
      make_blob(1, 2, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, TAIL_JUNK);
      send_blob();
      make_blob(2, 0, 1'b0, 32'd6, 32'd0, 32'd0, 32'd0, TAIL_FULL);
      send_blob();
      make_blob(3, 0, 1'b1, 32'd3, 32'd0, 32'd0, 32'd0, TAIL_NONE);
      send_blob();
      make_blob(3, 1, 1'b1, 32'd2, 32'd0, 32'd0, 32'd0, TAIL_WRONG);
      send_blob();
      make_blob(2, 0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, TAIL_PARTIAL);
      send_blob();
      make_blob(4, 0, 1'b1, 32'd4, 32'd0, 32'd2, 32'd3, TAIL_JUNK);
      send_blob();
      make_blob(5, 0, 1'b0, 32'd3, 32'd4, 32'd1, 32'd2, TAIL_NONE);
      send_blob();
      make_blob(5, 3, 1'b1, 32'hFFFF_FFF0, 32'd6, 32'd0, 32'd0, TAIL_FULL);
      send_blob();
      make_blob(2, 0, 1'b1, 32'd8, 32'd0, 32'd0, 32'd0, TAIL_CUT);
      send_blob();
      wait_drained();

      // ---------------------------------------------------------------------
      // Back pressure: the receiver holds off for a long stretch while short
      // rejected buffers keep coming, so results pile up and the input stalls.
      // Then the sender waits until every result has been delivered.
      // ---------------------------------------------------------------------
      hold_request = 1'b1;
      repeat (12) begin
         blob_bytes.delete();
         push_word({8'h4C, 8'($urandom), 8'($urandom), 8'($urandom_range(1, 255))});
         send_blob();
      end
      wait_drained();

      // ---------------------------------------------------------------------
      // Random buffers close the run with no idling on either side. Most are
      // well-formed versioned buffers with random content; the rest are
      // legacy, broken magics and plain noise.
      // ---------------------------------------------------------------------
      gaps_on      = 1'b0;
      rand_buffers = 0;
      while (bytes_sent < ITEM_TARGET || rand_buffers < TAIL_BUFFERS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            keep = $urandom_range(0, 99);
            if (keep < 25)      tail = TAIL_FULL;
            else if (keep < 45) tail = TAIL_NONE;
            else if (keep < 58) tail = TAIL_PARTIAL;
            else if (keep < 72) tail = TAIL_WRONG;
            else if (keep < 85) tail = TAIL_JUNK;
            else                tail = TAIL_CUT;
            keep = $urandom_range(0, 9);
            make_blob($urandom_range(1, 5),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                      1'($urandom_range(0, 1)), rand_size(), rand_size(),
                      keep < 4 ? 32'd0 : keep < 8 ? 32'($urandom_range(1, 5)) : $urandom,
                      rand_size(), tail);
         end else if (pick < 78) begin
            blob_bytes.delete();
            repeat ($urandom_range(0, 2)) blob_bytes.push_back(8'h00);
            push_word(bbhs_pkg::LEGACY_MAGIC);
            repeat ($urandom_range(0, 8)) blob_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 3) == 0) begin
               keep = $urandom_range(1, blob_bytes.size());
               while (blob_bytes.size() > keep) void'(blob_bytes.pop_back());
            end
         end else if (pick < 88) begin
            blob_bytes.delete();
            case ($urandom_range(0, 4))
               0:       push_word(bbhs_pkg::SIG_VALUE);
               1:       push_word(bbhs_pkg::SIG_VALUE | 32'd6);
               2:       push_word(bbhs_pkg::SIG_VALUE | 32'd7);
               3:       push_word(bbhs_pkg::SIG_VALUE | 32'($urandom_range(8, 255)));
               default: push_word($urandom);
            endcase
            repeat ($urandom_range(0, 6)) blob_bytes.push_back(8'($urandom));
         end else begin
            blob_bytes.delete();
            repeat ($urandom_range(1, 10))
               blob_bytes.push_back($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom));
         end
         send_blob();
         rand_buffers++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d buffers in %0d byte transfers, %0d results matched.",
               buffers_sent, bytes_sent, results_matched);
      $display("Mix: legacy, rejected, truncated, versions 1 to 5, trailers and blocks.");
      if (results_waiting != 0)
         $display("%0d expected results never arrived", results_waiting);
      if (mismatch_count == 0 && results_waiting == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bbhs_pkg.sv
rtl/bbhs_parser.sv
rtl/bbhs_out_buf.sv
rtl/binary_blob_header_skipper_top.sv
dv/bbhs_monitor.sv
dv/tb_top.sv
